// File: rtl/core/gimvn_pkg.sv
// Shared types and constants of the grey image mean/variance normalizer.
package gimvn_pkg;

	localparam int PIX_W     = 8;
	localparam int TM_W      = 8;
	localparam int TV_W      = 16;
	localparam int CFG_W     = 16;
	localparam int MEAN_W    = 16;
	localparam int VAR_W     = 24;
	localparam int GAIN_W    = 24;
	localparam int PROD_W    = 40;
	localparam int ROOT_IN_W = 56;
	localparam int ROOT_W    = 28;
	localparam int STAT_W    = 2;

	localparam logic OP_STATS = 1'b0;
	localparam logic OP_NORM  = 1'b1;

	localparam logic REG_TARGET_MEAN = 1'b0;
	localparam logic REG_TARGET_VAR  = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FLAT     = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_NO_STATS = 2'd2;
	localparam logic [STAT_W-1:0] STATUS_SAT      = 2'd3;

	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_VAR,
		DIV_GAIN
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M_LD,
		ST_M_RUN,
		ST_M_WR,
		ST_V_LD,
		ST_V_RUN,
		ST_SQ,
		ST_V_WR,
		ST_V_CHK,
		ST_G_LD,
		ST_G_RUN,
		ST_R_LD,
		ST_R_RUN,
		ST_COMMIT,
		ST_N_MUL,
		ST_N_OUT
	} state_t;

	typedef struct packed {
		logic     acc;
		logic     cap;
		logic     div_ld;
		div_sel_t div_sel;
		logic     div_step;
		logic     mean_wr;
		logic     mul_en;
		logic     mul_norm;
		logic     var_wr;
		logic     root_ld;
		logic     root_step;
		logic     commit;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic var_zero;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/core/gimvn_if.sv
// Stream channel interfaces for input pixels and normalized pixels.
interface gimvn_in_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [gimvn_pkg::PIX_W-1:0]   pixel_in;
	logic                          last_in;
	modport source (output valid, opcode, pixel_in, last_in, input ready);
	modport sink   (input valid, opcode, pixel_in, last_in, output ready);
endinterface

interface gimvn_out_if;
	logic                          valid;
	logic                          ready;
	logic [gimvn_pkg::PIX_W-1:0]   pixel_out;
	logic                          last_out;
	logic [gimvn_pkg::STAT_W-1:0]  status;
	modport source (output valid, pixel_out, last_out, status, input ready);
	modport sink   (input valid, pixel_out, last_out, status, output ready);
endinterface

// File: rtl/core/grey_image_mean_variance_normalizer.sv
// Top level of the grey image mean/variance normalizer.
// Usage: an image is streamed twice over the pix_in channel, one pixel per beat.
// The first pass (opcode 0) accumulates count, sum and sum of squares at one beat
// per cycle and gives no output; the beat with last_in set closes the pass.
// After that beat the block computes mean, variance and gain: three passes of a
// restoring divider (one quotient bit per cycle) plus a square root, with a
// flat image skipping the gain division and the root; during all this pix_in
// is not ready. The second pass (opcode 1) gives one beat on pix_out per pixel;
// each pixel goes through capture, multiply and result states in turn, one
// pixel at a time since the single multiplier is shared, and the result state
// loads the output register. Configuration writes (target mean at index 0,
// target variance at index 1) are taken on any cycle with cfg_we high and
// should only be made while the block is idle.
// The output register parts the two sides: a new input beat is taken while a
// result waits. When the receiver stalls with a result still waiting, the next
// result holds in the controller until the register frees up.
// Reset clears the accumulators, mean and gain and sets both targets to 100;
// a normalize pass before any statistics gives target_mean with status 2.
module grey_image_mean_variance_normalizer #(
	parameter int MAX_PIXELS = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gimvn_in_if.sink                      pix_in,
	gimvn_out_if.source                   pix_out,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [gimvn_pkg::CFG_W-1:0]   cfg_data
);

	// Dividend width covers both the shifted sum of squares and the gain quotient.
	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int DVD_W = (CNT_W + 24 > gimvn_pkg::ROOT_IN_W) ?
		CNT_W + 24 : gimvn_pkg::ROOT_IN_W;

	gimvn_pkg::cmd_t  cmd;
	gimvn_pkg::stat_t stat;

	gimvn_ctrl #(
		.DIV_STEPS (DVD_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_opcode (pix_in.opcode),
		.in_last   (pix_in.last_in),
		.in_ready  (pix_in.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gimvn_dp #(
		.MAX_PIXELS (MAX_PIXELS),
		.DVD_W      (DVD_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (pix_in.pixel_in),
		.last_in   (pix_in.last_in),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.pixel_out (pix_out.pixel_out),
		.last_out  (pix_out.last_out),
		.status    (pix_out.status)
	);

endmodule

// File: rtl/core/gimvn_ctrl.sv
// Controller state machine sequencing accumulation, divisions, root and output.
module gimvn_ctrl #(
	parameter int DIV_STEPS = 56
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_opcode,
	input  logic              in_last,
	output logic              in_ready,
	input  gimvn_pkg::stat_t  stat,
	output gimvn_pkg::cmd_t   cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	gimvn_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              cnt_clr, cnt_inc, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gimvn_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_clr)
				cnt_q <= '0;
			else if (cnt_inc)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	assign in_ready = (state_q == gimvn_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cnt_clr = 1'b0;
		cnt_inc = 1'b0;
		case (state_q)
			gimvn_pkg::ST_IDLE: begin
				if (accept && in_opcode == gimvn_pkg::OP_STATS) begin
					cmd.acc = 1'b1;
					if (in_last)
						state_d = gimvn_pkg::ST_M_LD;
				end else if (accept) begin
					cmd.cap = 1'b1;
					state_d = gimvn_pkg::ST_N_MUL;
				end
			end
			gimvn_pkg::ST_M_LD: begin
				cmd.div_ld  = 1'b1;
				cmd.div_sel = gimvn_pkg::DIV_MEAN;
				cnt_clr     = 1'b1;
				state_d     = gimvn_pkg::ST_M_RUN;
			end
			gimvn_pkg::ST_M_RUN: begin
				cmd.div_step = 1'b1;
				cnt_inc      = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = gimvn_pkg::ST_M_WR;
			end
			gimvn_pkg::ST_M_WR: begin
				cmd.mean_wr = 1'b1;
				state_d     = gimvn_pkg::ST_V_LD;
			end
			gimvn_pkg::ST_V_LD: begin
				cmd.div_ld  = 1'b1;
				cmd.div_sel = gimvn_pkg::DIV_VAR;
				cnt_clr     = 1'b1;
				state_d     = gimvn_pkg::ST_V_RUN;
			end
			gimvn_pkg::ST_V_RUN: begin
				cmd.div_step = 1'b1;
				cnt_inc      = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = gimvn_pkg::ST_SQ;
			end
			gimvn_pkg::ST_SQ: begin
				cmd.mul_en = 1'b1;
				state_d    = gimvn_pkg::ST_V_WR;
			end
			gimvn_pkg::ST_V_WR: begin
				cmd.var_wr = 1'b1;
				state_d    = gimvn_pkg::ST_V_CHK;
			end
			gimvn_pkg::ST_V_CHK: begin
				state_d = stat.var_zero ? gimvn_pkg::ST_COMMIT : gimvn_pkg::ST_G_LD;
			end
			gimvn_pkg::ST_G_LD: begin
				cmd.div_ld  = 1'b1;
				cmd.div_sel = gimvn_pkg::DIV_GAIN;
				cnt_clr     = 1'b1;
				state_d     = gimvn_pkg::ST_G_RUN;
			end
			gimvn_pkg::ST_G_RUN: begin
				cmd.div_step = 1'b1;
				cnt_inc      = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = gimvn_pkg::ST_R_LD;
			end
			gimvn_pkg::ST_R_LD: begin
				cmd.root_ld = 1'b1;
				cnt_clr     = 1'b1;
				state_d     = gimvn_pkg::ST_R_RUN;
			end
			gimvn_pkg::ST_R_RUN: begin
				cmd.root_step = 1'b1;
				cnt_inc       = 1'b1;
				if (cnt_q == CNT_W'(gimvn_pkg::ROOT_W - 1))
					state_d = gimvn_pkg::ST_COMMIT;
			end
			gimvn_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = gimvn_pkg::ST_IDLE;
			end
			gimvn_pkg::ST_N_MUL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_norm = 1'b1;
				state_d      = gimvn_pkg::ST_N_OUT;
			end
			gimvn_pkg::ST_N_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = gimvn_pkg::ST_IDLE;
				end
			end
			default: state_d = gimvn_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: rtl/core/gimvn_dp.sv
// Datapath: accumulators, shared divider, square root, multiplier, output register.
module gimvn_dp #(
	parameter int MAX_PIXELS = 1048576,
	parameter int DVD_W      = 56
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gimvn_pkg::cmd_t                   cmd,
	output gimvn_pkg::stat_t                  stat,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [gimvn_pkg::CFG_W-1:0]       cfg_data,
	input  logic [gimvn_pkg::PIX_W-1:0]       pixel_in,
	input  logic                              last_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gimvn_pkg::PIX_W-1:0]       pixel_out,
	output logic                              last_out,
	output logic [gimvn_pkg::STAT_W-1:0]      status
);

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W = CNT_W + 8;
	localparam int SQ_W  = CNT_W + 16;
	localparam int DIV_W = (CNT_W > gimvn_pkg::VAR_W) ? CNT_W : gimvn_pkg::VAR_W;
	localparam int RR_W  = gimvn_pkg::ROOT_W + 4;

	logic [gimvn_pkg::TM_W-1:0]    tm_q;
	logic [gimvn_pkg::TV_W-1:0]    tv_q;
	logic [SUM_W-1:0]              pix_total_q;
	logic [SQ_W-1:0]               sq_total_q;
	logic [CNT_W-1:0]              pix_cnt_q;
	logic [gimvn_pkg::MEAN_W-1:0]  mean_q;
	logic [gimvn_pkg::GAIN_W-1:0]  gain_q;
	logic                          ready_q, flat_q;
	logic [gimvn_pkg::VAR_W-1:0]   var_q;

	logic [DVD_W-1:0]              dvd_q, quo_q;
	logic [DIV_W-1:0]              dvs_q, rem_q;
	logic [DIV_W:0]                rem_sh;
	logic                          q_bit;

	logic [gimvn_pkg::ROOT_IN_W-1:0] root_in_q;
	logic [gimvn_pkg::ROOT_W-1:0]    root_q;
	logic [RR_W-1:0]                 rrem_q, rrem_sh, trial;

	logic [gimvn_pkg::PIX_W-1:0]   px_q;
	logic                          last_q;
	logic [gimvn_pkg::MEAN_W-1:0]  p8, delta;
	logic                          below;
	logic [gimvn_pkg::GAIN_W-1:0]  mul_a;
	logic [gimvn_pkg::MEAN_W-1:0]  mul_b;
	logic [gimvn_pkg::PROD_W-1:0]  prod_s1;

	logic [gimvn_pkg::VAR_W-1:0]   mean_sq, var_raw;
	logic [gimvn_pkg::PROD_W-1:0]  base;
	logic [gimvn_pkg::PROD_W:0]    up_sum;
	logic [gimvn_pkg::PROD_W-1:0]  dn_diff;
	logic [gimvn_pkg::PIX_W-1:0]   res_pix;
	logic [gimvn_pkg::STAT_W-1:0]  res_stat;
	logic                          out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tm_q <= gimvn_pkg::TM_W'(100);
			tv_q <= gimvn_pkg::TV_W'(100);
		end else if (cfg_we) begin
			if (cfg_index == gimvn_pkg::REG_TARGET_MEAN)
				tm_q <= cfg_data[gimvn_pkg::TM_W-1:0];
			else
				tv_q <= cfg_data[gimvn_pkg::TV_W-1:0];
		end
	end

	// Accumulators and image statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_total_q <= '0;
			sq_total_q  <= '0;
			pix_cnt_q   <= '0;
			mean_q      <= '0;
			gain_q      <= '0;
			ready_q     <= 1'b0;
			flat_q      <= 1'b0;
		end else begin
			if (cmd.acc && pix_cnt_q < CNT_W'(MAX_PIXELS)) begin
				pix_total_q <= pix_total_q + SUM_W'(pixel_in);
				sq_total_q  <= sq_total_q + SQ_W'({8'h00, pixel_in} * {8'h00, pixel_in});
				pix_cnt_q   <= pix_cnt_q + 1'b1;
			end
			if (cmd.mean_wr)
				mean_q <= quo_q[gimvn_pkg::MEAN_W-1:0];
			if (cmd.commit) begin
				ready_q     <= 1'b1;
				pix_total_q <= '0;
				sq_total_q  <= '0;
				pix_cnt_q   <= '0;
				if (var_q == '0) begin
					flat_q <= 1'b1;
					gain_q <= '0;
				end else begin
					flat_q <= 1'b0;
					gain_q <= (root_q[gimvn_pkg::ROOT_W-1:gimvn_pkg::GAIN_W] != '0) ?
						'1 : root_q[gimvn_pkg::GAIN_W-1:0];
				end
			end
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.div_ld) begin
			rem_q <= '0;
			quo_q <= '0;
			case (cmd.div_sel)
				gimvn_pkg::DIV_MEAN: begin
					dvd_q <= DVD_W'({pix_total_q, 8'h00});
					dvs_q <= (pix_cnt_q == '0) ? DIV_W'(1) : DIV_W'(pix_cnt_q);
				end
				gimvn_pkg::DIV_VAR: begin
					dvd_q <= DVD_W'({sq_total_q, 8'h00});
					dvs_q <= (pix_cnt_q == '0) ? DIV_W'(1) : DIV_W'(pix_cnt_q);
				end
				default: begin
					dvd_q <= DVD_W'({tv_q, 40'h0});
					dvs_q <= DIV_W'(var_q);
				end
			endcase
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? DIV_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], q_bit};
		end
	end

	// Digit-by-digit square root, two radicand bits per cycle.
	assign rrem_sh = {rrem_q[RR_W-3:0], root_in_q[gimvn_pkg::ROOT_IN_W-1 -: 2]};
	assign trial   = RR_W'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.root_ld) begin
			root_in_q <= quo_q[gimvn_pkg::ROOT_IN_W-1:0];
			root_q    <= '0;
			rrem_q    <= '0;
		end else if (cmd.root_step) begin
			root_in_q <= {root_in_q[gimvn_pkg::ROOT_IN_W-3:0], 2'b00};
			if (rrem_sh >= trial) begin
				rrem_q <= rrem_sh - trial;
				root_q <= {root_q[gimvn_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rrem_q <= rrem_sh;
				root_q <= {root_q[gimvn_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Shared multiplier: mean squared during statistics, gain times distance otherwise.
	assign p8    = {px_q, 8'h00};
	assign below = (p8 <= mean_q);
	assign delta = below ? mean_q - p8 : p8 - mean_q;
	assign mul_a = cmd.mul_norm ? gain_q : gimvn_pkg::GAIN_W'(mean_q);
	assign mul_b = cmd.mul_norm ? delta : mean_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			px_q   <= pixel_in;
			last_q <= last_in;
		end
		if (cmd.mul_en)
			prod_s1 <= {16'h0000, mul_a} * {24'h000000, mul_b};
	end

	// Variance from the mean of squares and the squared mean.
	assign mean_sq = prod_s1[31:8];
	assign var_raw = quo_q[gimvn_pkg::VAR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.var_wr)
			var_q <= (var_raw >= mean_sq) ? var_raw - mean_sq : '0;
	end

	// Result of one normalized pixel.
	assign base    = gimvn_pkg::PROD_W'({tm_q, 24'h0});
	assign up_sum  = {1'b0, base} + {1'b0, prod_s1};
	assign dn_diff = base - prod_s1;

	always_comb begin
		res_pix  = tm_q;
		res_stat = gimvn_pkg::STATUS_OK;
		if (!ready_q) begin
			res_stat = gimvn_pkg::STATUS_NO_STATS;
		end else if (flat_q) begin
			res_stat = gimvn_pkg::STATUS_FLAT;
		end else if (below) begin
			if (prod_s1 > base) begin
				res_pix  = '0;
				res_stat = gimvn_pkg::STATUS_SAT;
			end else begin
				res_pix = dn_diff[31:24];
			end
		end else begin
			if (up_sum[gimvn_pkg::PROD_W:32] != '0) begin
				res_pix  = '1;
				res_stat = gimvn_pkg::STATUS_SAT;
			end else begin
				res_pix = up_sum[31:24];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_out <= res_pix;
			last_out  <= last_q;
			status    <= res_stat;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.var_zero = (var_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	a_commit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> ready_q && pix_cnt_q == '0)
		else $error("commit did not publish statistics and clear the accumulators");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.div_step && cmd.root_step))
		else $error("divider and root stepped in the same cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while held");

	a_flat_gain: assert property (@(posedge clk) disable iff (!arst_n)
		flat_q |-> gain_q == '0)
		else $error("flat image with nonzero gain");

endmodule

// File: verif/gimvn_checker.sv
`timescale 1ns / 1ps
// Checker of the grey image normalizer: predicts normalized pixels and compares them.
module gimvn_checker (
	input  logic             clk,
	input  logic             arst_n,
	gimvn_in_if.sink         pix_in,
	gimvn_out_if.sink        pix_out,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [7:0]                  pix;
		logic                        last;
		logic [gimvn_pkg::STAT_W-1:0] status;
	} norm_beat_t;

	localparam longint unsigned PIXEL_LIMIT = 1048576;

	longint unsigned tgt_mean, tgt_var;
	longint unsigned sum_pix, sum_sq, n_pix, mean_q, gain_q;
	bit have_stats, is_flat;
	norm_beat_t expected_q[$];

	assign pending = expected_q.size();

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// Closes a statistics pass: mean, variance and gain, then clears the sums.
	task automatic close_stats();
		longint unsigned n, msq, v, g;
		n = (n_pix == 0) ? 1 : n_pix;
		mean_q = ((sum_pix << 8) / n) & 16'hFFFF;
		msq = (mean_q * mean_q) >> 8;
		v = (sum_sq << 8) / n;
		v = (v >= msq) ? v - msq : 0;
		if (v == 0) begin
			is_flat = 1;
			gain_q = 0;
		end else begin
			is_flat = 0;
			g = isqrt((tgt_var << 40) / v);
			gain_q = (g > 24'hFFFFFF) ? 24'hFFFFFF : g;
		end
		have_stats = 1;
		sum_pix = 0;
		sum_sq = 0;
		n_pix = 0;
	endtask

	function automatic norm_beat_t normalize(logic [7:0] p, logic last);
		norm_beat_t r;
		longint unsigned p8, base, prod, t;
		r.last = last;
		r.status = gimvn_pkg::STATUS_OK;
		p8 = longint'(p) << 8;
		base = tgt_mean << 24;
		if (!have_stats) begin
			r.pix = 8'(tgt_mean);
			r.status = gimvn_pkg::STATUS_NO_STATS;
		end else if (is_flat) begin
			r.pix = 8'(tgt_mean);
			r.status = gimvn_pkg::STATUS_FLAT;
		end else if (p8 <= mean_q) begin
			prod = gain_q * (mean_q - p8);
			if (prod > base) begin
				r.pix = 8'd0;
				r.status = gimvn_pkg::STATUS_SAT;
			end else begin
				r.pix = 8'((base - prod) >> 24);
			end
		end else begin
			t = (base + gain_q * (p8 - mean_q)) >> 24;
			if (t > 255) begin
				r.pix = 8'd255;
				r.status = gimvn_pkg::STATUS_SAT;
			end else begin
				r.pix = 8'(t);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		norm_beat_t exp_b;
		if (!arst_n) begin
			tgt_mean = 100;
			tgt_var = 100;
			sum_pix = 0;
			sum_sq = 0;
			n_pix = 0;
			mean_q = 0;
			gain_q = 0;
			have_stats = 0;
			is_flat = 0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == gimvn_pkg::REG_TARGET_MEAN) tgt_mean = cfg_data[7:0];
				else tgt_var = cfg_data;
			end
			if (pix_in.valid && pix_in.ready) begin
				if (pix_in.opcode == gimvn_pkg::OP_STATS) begin
					if (n_pix < PIXEL_LIMIT) begin
						sum_pix += pix_in.pixel_in;
						sum_sq += pix_in.pixel_in * pix_in.pixel_in;
						n_pix++;
					end
					if (pix_in.last_in) close_stats();
				end else begin
					expected_q.push_back(normalize(pix_in.pixel_in, pix_in.last_in));
				end
			end
			if (pix_out.valid && pix_out.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected output beat pixel_out=%0d", pix_out.pixel_out);
					fail_count++;
				end else begin
					exp_b = expected_q.pop_front();
					if (pix_out.pixel_out !== exp_b.pix) begin
						$error("pixel_out expected %0d actual %0d", exp_b.pix, pix_out.pixel_out);
						fail_count++;
					end
					if (pix_out.last_out !== exp_b.last) begin
						$error("last_out expected %0d actual %0d", exp_b.last, pix_out.last_out);
						fail_count++;
					end
					if (pix_out.status !== exp_b.status) begin
						$error("status expected %0d actual %0d", exp_b.status, pix_out.status);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the grey image normalizer testbench: stimulus, reset and verdict.
module testbench;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;
	longint      cycles;
	bit          hold_off;
	bit          noise_on;

	gimvn_in_if  pix_in ();
	gimvn_out_if pix_out ();

	grey_image_mean_variance_normalizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.pix_out  (pix_out),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	gimvn_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Watchdog. The slowest run: about 1650 beats, each with random idling on
	// both sides plus the block's own processing, plus the closing arithmetic of
	// each finished statistics pass and the wait of each register write, even when
	// every image is a single pixel; the limit below is several times that.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1000000) begin
				$display("grey_image_mean_variance_normalizer: mismatch");
				$finish;
			end
		end
	end

	// Receiver. Each beat may first hold ready low for a randomly drawn gap, except
	// when random idling is off. When set, hold_off keeps ready low for a long
	// stretch so the block backs up into its input.
	initial begin
		int gap;
		pix_out.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				pix_out.ready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			gap = noise_on ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				pix_out.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			pix_out.ready <= 1;
			@(posedge clk);
			while (!pix_out.valid) @(posedge clk);
		end
	end

	// Offers one beat and waits until the block takes it.
	task automatic send_beat(logic op, logic [7:0] p, logic last);
		int gap;
		gap = noise_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			pix_in.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid    <= 1;
		pix_in.opcode   <= op;
		pix_in.pixel_in <= p;
		pix_in.last_in  <= last;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		pix_in.valid <= 0;
	endtask

	// Configuration is written only with nothing in flight; the extra cycles
	// cover a statistics pass whose closing arithmetic is still running.
	task automatic write_reg(logic idx, logic [15:0] val);
		while (pending != 0) @(posedge clk);
		repeat (260) @(posedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// One image: a statistics pass and then one or two normalize passes over
	// the same pixels. Pixels come from a random band so that variances and
	// gains vary widely; some images are flat. Adds the beats sent to sent.
	task automatic send_image(int n, inout int sent);
		logic [7:0] img[$];
		int lo, hi, reps;
		lo = $urandom_range(0, 255);
		hi = $urandom_range(lo, 255);
		if ($urandom_range(0, 9) == 0) hi = lo;
		for (int i = 0; i < n; i++) img.push_back(8'($urandom_range(lo, hi)));
		for (int i = 0; i < n; i++) send_beat(gimvn_pkg::OP_STATS, img[i], i == n - 1);
		reps = $urandom_range(1, 2);
		for (int r = 0; r < reps; r++)
			for (int i = 0; i < n; i++) send_beat(gimvn_pkg::OP_NORM, img[i], i == n - 1);
		sent += n * (1 + reps);
	endtask

	initial begin
		int sent;
		hold_off     = 0;
		noise_on     = 0;
		arst_n       = 0;
		cfg_we       = 0;
		cfg_index    = 0;
		cfg_data     = 0;
		pix_in.valid = 0;
		pix_in.opcode   = 0;
		pix_in.pixel_in = 0;
		pix_in.last_in  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Normalize before any statistics: target mean, no-statistics status.
		send_beat(gimvn_pkg::OP_NORM, 8'd0, 0);
		send_beat(gimvn_pkg::OP_NORM, 8'd255, 1);
		// Flat image of 255s, then the normalized pass gives the flat status.
		send_beat(gimvn_pkg::OP_STATS, 8'd255, 0);
		send_beat(gimvn_pkg::OP_STATS, 8'd255, 1);
		send_beat(gimvn_pkg::OP_NORM, 8'd255, 1);
		// A lone last beat closes a one-pixel pass.
		send_beat(gimvn_pkg::OP_STATS, 8'd7, 1);
		send_beat(gimvn_pkg::OP_NORM, 8'd7, 1);
		// Extreme contrast with a huge target variance saturates both ways.
		write_reg(gimvn_pkg::REG_TARGET_VAR, 16'hFFFF);
		write_reg(gimvn_pkg::REG_TARGET_MEAN, 16'd128);
		send_beat(gimvn_pkg::OP_STATS, 8'd0, 0);
		send_beat(gimvn_pkg::OP_STATS, 8'd255, 0);
		send_beat(gimvn_pkg::OP_STATS, 8'd128, 1);
		send_beat(gimvn_pkg::OP_NORM, 8'd0, 0);
		send_beat(gimvn_pkg::OP_NORM, 8'd255, 0);
		send_beat(gimvn_pkg::OP_NORM, 8'd128, 0);
		send_beat(gimvn_pkg::OP_NORM, 8'd127, 1);
		// Small spread with a zero target: the gain is zero.
		write_reg(gimvn_pkg::REG_TARGET_VAR, 16'd0);
		write_reg(gimvn_pkg::REG_TARGET_MEAN, 16'd255);
		send_beat(gimvn_pkg::OP_STATS, 8'd170, 0);
		send_beat(gimvn_pkg::OP_STATS, 8'd85, 1);
		send_beat(gimvn_pkg::OP_NORM, 8'd170, 0);
		send_beat(gimvn_pkg::OP_NORM, 8'd85, 1);
		write_reg(gimvn_pkg::REG_TARGET_VAR, 16'd1);
		write_reg(gimvn_pkg::REG_TARGET_MEAN, 16'd0);
		send_beat(gimvn_pkg::OP_STATS, 8'd100, 0);
		send_beat(gimvn_pkg::OP_STATS, 8'd101, 1);
		send_beat(gimvn_pkg::OP_NORM, 8'd100, 0);
		send_beat(gimvn_pkg::OP_NORM, 8'd101, 1);

		// Random phase: mostly whole images under varied targets, some stray
		// normalize beats, and long receiver hold-offs.
		noise_on = 1;
		sent = 0;
		while (sent < 1650) begin
			if ($urandom_range(0, 5) == 0) begin
				write_reg(gimvn_pkg::REG_TARGET_MEAN, 16'($urandom_range(0, 255)));
				case ($urandom_range(0, 3))
					0: write_reg(gimvn_pkg::REG_TARGET_VAR, 16'd0);
					1: write_reg(gimvn_pkg::REG_TARGET_VAR, 16'hFFFF);
					default: write_reg(gimvn_pkg::REG_TARGET_VAR, 16'($urandom_range(0, 65535)));
				endcase
			end
			if (sent > 400 && sent < 500) begin
				noise_on = 0;
				hold_off = 1;
				send_image(20, sent);
				noise_on = 1;
			end else if ($urandom_range(0, 7) == 0) begin
				send_beat(gimvn_pkg::OP_NORM, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				sent++;
			end else begin
				send_image($urandom_range(1, 12), sent);
			end
		end

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("grey_image_mean_variance_normalizer: match");
		end else begin
			$display("grey_image_mean_variance_normalizer: mismatch");
		end
		$finish;
	end
endmodule
